FILE: design/assert_macros.svh
// Assertion macros shared by the matrix block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: design/mat3_pkg.sv
// Shared types and constants of the 3x3 matrix add, subtract and multiply block.
package mat3_pkg;

   localparam int DIM_DEFAULT         = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int ELEM_W              = 16;
   localparam int RES_W               = 33;
   localparam int OP_W                = 2;

   // Operation codes carried on the completing beat.
   localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL  = 2'd2;
   localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

   typedef struct packed {
      logic signed [ELEM_W-1:0] a_elem;
      logic signed [ELEM_W-1:0] b_elem;
      logic [OP_W-1:0]          req_type;
   } req_beat_type;

   typedef struct packed {
      logic signed [RES_W-1:0] result_value;
      logic                    last;
   } rsp_beat_type;

   // One classified load beat as it travels from front to back.
   typedef struct packed {
      logic signed [ELEM_W-1:0] a_elem;
      logic signed [ELEM_W-1:0] b_elem;
      logic [OP_W-1:0]          req_type;
      logic                     final_item;
   } queue_entry_type;

   // Status of the back end, watched at the top level.
   typedef struct packed {
      logic in_calc;
      logic wr_at_start;
      logic busy;
   } back_status_type;

endpackage

FILE: design/mat3_front.sv
// Front end: accepts load beats, tracks the load position and marks the completing beat.
module mat3_front import mat3_pkg::*; #(
   parameter int DIM = DIM_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_beat_type    req_data,
   input  logic            q_full,
   output logic            q_push,
   output queue_entry_type q_entry,
   output logic            at_start
);

   localparam int NELEM = DIM * DIM;
   localparam int IDX_W = $clog2(NELEM);

   logic [IDX_W-1:0] load_cnt_ff;
   logic [IDX_W-1:0] load_cnt_in;
   logic             is_final;

   // The queue is the only reason to hold the producer back.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign is_final  = (load_cnt_ff == IDX_W'(NELEM - 1));
   assign at_start  = (load_cnt_ff == '0);

   // Build the queue entry from the beat and its classification.
   always_comb begin
      q_entry.a_elem     = req_data.a_elem;
      q_entry.b_elem     = req_data.b_elem;
      q_entry.req_type   = req_data.req_type;
      q_entry.final_item = is_final;
   end

   // Load position wraps to zero after the completing beat.
   always_comb begin
      load_cnt_in = load_cnt_ff;
      if (q_push) begin
         load_cnt_in = is_final ? '0 : load_cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
      end else begin
         load_cnt_ff <= load_cnt_in;
      end
   end

endmodule

FILE: design/mat3_queue.sv
// Short queue of classified load beats between the front and back ends.
module mat3_queue import mat3_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   output logic            head_valid,
   output queue_entry_type head,
   input  logic            pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/mat3_back.sv
// Back end: stores both matrices and computes the result elements on one shared MAC path.
module mat3_back import mat3_pkg::*; #(
   parameter int DIM = DIM_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  queue_entry_type q_head,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_beat_type    rsp_data,
   output back_status_type status
);

   localparam int NELEM = DIM * DIM;
   localparam int IDX_W = $clog2(NELEM);
   localparam int CW    = $clog2(DIM);
   localparam int SUM_W = ELEM_W + 1;
   localparam int PRD_W = 2 * ELEM_W;

   typedef enum logic {
      ST_LOAD,
      ST_CALC
   } state_type;

   // Operand stores, written by load beats and read during computation.
   logic signed [ELEM_W-1:0] left_mem  [NELEM];
   logic signed [ELEM_W-1:0] right_mem [NELEM];
   logic signed [ELEM_W-1:0] l_rd_ff;
   logic signed [ELEM_W-1:0] r_rd_ff;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         wr_cnt_ff, wr_cnt_in;
   logic                     mul_ff, mul_in;
   logic                     sub_ff, sub_in;
   logic [CW-1:0]            row_ff, row_in;
   logic [CW-1:0]            col_ff, col_in;
   logic [CW-1:0]            k_ff, k_in;
   logic                     busy_ff, busy_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_firstk_ff, s1_firstk_in;
   logic                     s1_lastk_ff, s1_lastk_in;
   logic                     s1_lastel_ff, s1_lastel_in;
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_firstk_ff, s2_firstk_in;
   logic                     s2_lastk_ff, s2_lastk_in;
   logic                     s2_lastel_ff, s2_lastel_in;
   logic signed [RES_W-1:0]  term_ff, term_in;
   logic signed [RES_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_beat_type             rsp_data_ff, rsp_data_in;

   logic                     mul_dec;
   logic                     sub_dec;
   logic                     issue;
   logic                     lastk;
   logic                     lastel;
   logic                     rsp_taken;
   logic [IDX_W-1:0]         l_addr;
   logic [IDX_W-1:0]         r_addr;
   logic [IDX_W-1:0]         el_addr;
   logic signed [PRD_W-1:0]  prod;
   logic signed [SUM_W-1:0]  sum_v;

   assign q_pop     = (state_ff == ST_LOAD) && q_valid;
   assign rsp_taken = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.in_calc     = (state_ff == ST_CALC);
   assign status.wr_at_start = (wr_cnt_ff == '0);
   assign status.busy        = busy_ff;

   // Operation decode on the completing beat; the spare code multiplies.
   always_comb begin
      mul_dec = 1'b0;
      sub_dec = 1'b0;
      unique case (q_head.req_type) inside
         OP_MUL, OP_RSVD: mul_dec = 1'b1;
         OP_SUB:          sub_dec = 1'b1;
         OP_ADD:          mul_dec = 1'b0;
      endcase
   end

   // One read per store per cycle: a new element starts only once the last one has left.
   assign issue  = (state_ff == ST_CALC) && (!busy_ff || (k_ff != '0));
   assign lastk  = !mul_ff || (k_ff == CW'(DIM - 1));
   assign lastel = (row_ff == CW'(DIM - 1)) && (col_ff == CW'(DIM - 1));

   // Store addresses for the current term.
   assign el_addr = IDX_W'(row_ff) * IDX_W'(DIM) + IDX_W'(col_ff);
   assign l_addr  = mul_ff ? IDX_W'(row_ff) * IDX_W'(DIM) + IDX_W'(k_ff) : el_addr;
   assign r_addr  = mul_ff ? IDX_W'(k_ff) * IDX_W'(DIM) + IDX_W'(col_ff) : el_addr;

   // Term formation: product or sum/difference, widened to the result width.
   assign prod  = l_rd_ff * r_rd_ff;
   assign sum_v = sub_ff ? SUM_W'(l_rd_ff) - SUM_W'(r_rd_ff)
                         : SUM_W'(l_rd_ff) + SUM_W'(r_rd_ff);

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in     = state_ff;
      wr_cnt_in    = wr_cnt_ff;
      mul_in       = mul_ff;
      sub_in       = sub_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      acc_in       = s2_firstk_ff ? term_ff : acc_ff + term_ff;

      // Loading: count stored beats and start computing on the completing one.
      if (q_pop) begin
         if (q_head.final_item) begin
            wr_cnt_in = '0;
            mul_in    = mul_dec;
            sub_in    = sub_dec;
            row_in    = '0;
            col_in    = '0;
            k_in      = '0;
            state_in  = ST_CALC;
         end else begin
            wr_cnt_in = wr_cnt_ff + IDX_W'(1);
         end
      end

      // Issue one term and step the element and inner counters.
      if (issue) begin
         busy_in = 1'b1;
         if (lastk) begin
            k_in = '0;
            if (col_ff == CW'(DIM - 1)) begin
               col_in = '0;
               row_in = (row_ff == CW'(DIM - 1)) ? '0 : row_ff + CW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
            if (lastel) begin
               state_in = ST_LOAD;
            end
         end else begin
            k_in = k_ff + CW'(1);
         end
      end

      // The output register frees the element path once it is taken.
      if (rsp_taken) begin
         rsp_valid_in = 1'b0;
         busy_in      = 1'b0;
      end
      if (s2_valid_ff && s2_lastk_ff) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.result_value = acc_in;
         rsp_data_in.last         = s2_lastel_ff;
      end

      s1_valid_in  = issue;
      s1_firstk_in = (k_ff == '0);
      s1_lastk_in  = lastk;
      s1_lastel_in = lastel;
      s2_valid_in  = s1_valid_ff;
      s2_firstk_in = s1_firstk_ff;
      s2_lastk_in  = s1_lastk_ff;
      s2_lastel_in = s1_lastel_ff;
      term_in      = mul_ff ? RES_W'(prod) : RES_W'(sum_v);
   end

   // State, pipeline and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         wr_cnt_ff    <= '0;
         busy_ff      <= 1'b0;
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_cnt_ff    <= wr_cnt_in;
         busy_ff      <= busy_in;
         k_ff         <= k_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mul_ff       <= mul_in;
      sub_ff       <= sub_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      s1_firstk_ff <= s1_firstk_in;
      s1_lastk_ff  <= s1_lastk_in;
      s1_lastel_ff <= s1_lastel_in;
      s2_firstk_ff <= s2_firstk_in;
      s2_lastk_ff  <= s2_lastk_in;
      s2_lastel_ff <= s2_lastel_in;
      term_ff      <= term_in;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      rsp_data_ff  <= rsp_data_in;
   end

   // Operand stores with registered read data.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         left_mem[wr_cnt_ff]  <= q_head.a_elem;
         right_mem[wr_cnt_ff] <= q_head.b_elem;
      end
      l_rd_ff <= left_mem[l_addr];
      r_rd_ff <= right_mem[r_addr];
   end

endmodule

FILE: design/matrix3x3_add_sub_mul.sv
// Top level of the DIM x DIM signed matrix add, subtract and multiply block.
// Each request beat carries one element of the left and one of the right matrix in
// row-major order; the beat that completes a load picks the operation (add, subtract,
// or multiply, the spare code multiplying) and the block then returns DIM*DIM result
// beats in row-major order, the final one flagged with last. Load beats drain from a
// short queue at one per cycle while the back end is loading. Results come from a single
// shared multiply-accumulate path that works on one element at a time, each element
// ending when the output register is taken. The tail of the last element overlaps the
// next load. While a round is being computed the queue keeps taking the next matrix's
// first beats.
`include "assert_macros.svh"

module matrix3x3_add_sub_mul import mat3_pkg::*; #(
   parameter int DIM         = DIM_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_data
);

   queue_entry_type q_entry;
   queue_entry_type q_head;
   logic            q_push;
   logic            q_full;
   logic            q_valid;
   logic            q_pop;
   logic            front_at_start;
   back_status_type back_status;

   // Front end: accepts and classifies load beats.
   mat3_front #(
      .DIM(DIM)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry),
      .at_start (front_at_start)
   );

   // Queue decoupling the two ends.
   mat3_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .full      (q_full),
      .head_valid(q_valid),
      .head      (q_head),
      .pop       (q_pop)
   );

   // Back end: stores operands and produces results.
   mat3_back #(
      .DIM(DIM)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .status   (back_status)
   );

   // The back end only drains the queue while loading.
   `ASSERT_IMPLIES(a_pop_only_in_load, clock, reset, q_pop, !back_status.in_calc)
   // Computation starts only after the completing beat has been popped.
   `ASSERT_IMPLIES(a_calc_after_final, clock, reset,
      $rose(back_status.in_calc), $past(q_pop && q_head.final_item))
   // With the queue drained and the back end loading, both load positions agree.
   `ASSERT_IMPLIES(a_count_agree, clock, reset,
      !q_valid && !back_status.in_calc, front_at_start == back_status.wr_at_start)
   // An element in flight keeps the path busy until its result beat is taken.
   `ASSERT_NEXT(a_busy_until_taken, clock, reset,
      back_status.busy && !(rsp_valid && !rsp_stall), back_status.busy)

endmodule

FILE: dv/matrix3x3_add_sub_mul_check.sv
// Checker for the matrix block: predicts each result beat and compares it with the output.
module matrix3x3_add_sub_mul_check import mat3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_beat_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_beat_type rsp_data,
   output int           fail_count,
   output int           pending
);

   localparam int ROWS  = DIM_DEFAULT;
   localparam int ELEMS = DIM_DEFAULT * DIM_DEFAULT;

   // Own copy of the two operand matrices and the position of the next load beat.
   logic signed [ELEM_W-1:0] left_elems  [ELEMS];
   logic signed [ELEM_W-1:0] right_elems [ELEMS];
   int                       fill_index;

   // Result beats still owed by the block, oldest first.
   rsp_beat_type             owed_results [$];
   int                       mismatch_total;

   // Queues the whole result matrix of one completed load.
   function automatic void queue_round(input logic [OP_W-1:0] op);
      rsp_beat_type beat;
      longint       acc;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < ROWS; c++) begin
            acc = 0;
            if (op == OP_MUL || op == OP_RSVD) begin
               // The spare code multiplies as well.
               for (int k = 0; k < ROWS; k++) begin
                  acc += longint'(left_elems[r*ROWS + k]) * longint'(right_elems[k*ROWS + c]);
               end
            end else if (op == OP_SUB) begin
               acc = longint'(left_elems[r*ROWS + c]) - longint'(right_elems[r*ROWS + c]);
            end else begin
               acc = longint'(left_elems[r*ROWS + c]) + longint'(right_elems[r*ROWS + c]);
            end
            beat.result_value = acc[RES_W-1:0];
            beat.last         = (r == ROWS - 1) && (c == ROWS - 1);
            owed_results.push_back(beat);
         end
      end
   endfunction

   function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
      mismatch_total++;
      if (mismatch_total <= 10) begin
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         fill_index = 0;
         owed_results.delete();
      end else begin
         // Result side first: a beat cannot leave in the cycle its load completes.
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               note_mismatch("unexpected result beat", 0, rsp_data.result_value);
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  note_mismatch("result_value", want.result_value, rsp_data.result_value);
               end
               if (rsp_data.last !== want.last) begin
                  note_mismatch("last", want.last, rsp_data.last);
               end
            end
         end

         // Load side: store the pair, and on the completing beat work out the results.
         if (req_valid && !req_stall) begin
            left_elems[fill_index]  = req_data.a_elem;
            right_elems[fill_index] = req_data.b_elem;
            if (fill_index == ELEMS - 1) begin
               fill_index = 0;
               queue_round(req_data.req_type);
            end else begin
               fill_index++;
            end
         end
      end
      pending    <= owed_results.size();
      fail_count <= mismatch_total;
   end

endmodule

FILE: dv/matrix3x3_add_sub_mul_test.sv
// Testbench top for the matrix block: clock, reset, load stimulus, result stalls and verdict.
module matrix3x3_add_sub_mul_test;
   import mat3_pkg::*;

   localparam int ELEMS        = DIM_DEFAULT * DIM_DEFAULT;
   localparam int RANDOM_ROUNDS = 46;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 80;

   localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
   localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_data;

   int           fail_count;
   int           pending;
   int           cycle_count = 0;
   bit           sender_calm = 1'b0;

   always #2 clock = ~clock;

   matrix3x3_add_sub_mul dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   matrix3x3_add_sub_mul_check result_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   // Element value with the extremes and small values favoured now and then.
   function automatic logic signed [ELEM_W-1:0] random_elem();
      logic signed [ELEM_W-1:0] value;
      case ($urandom_range(0, 11))
         0: value = ELEM_MIN;
         1: value = ELEM_MAX;
         2: value = '0;
         3: value = '1;
         default: value = ELEM_W'($urandom());
      endcase
      return value;
   endfunction

   // Offers one load beat and holds it until taken, then may idle for a while.
   task automatic send_beat(input req_beat_type beat);
      int gap;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      gap = sender_calm ? 0 : idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Loads a full pair of matrices; the operation rides on the completing beat only.
   task automatic send_matrices(input logic signed [ELEM_W-1:0] a_vals [ELEMS],
                                input logic signed [ELEM_W-1:0] b_vals [ELEMS],
                                input logic [OP_W-1:0]          op);
      req_beat_type beat;
      for (int k = 0; k < ELEMS; k++) begin
         beat.a_elem   = a_vals[k];
         beat.b_elem   = b_vals[k];
         beat.req_type = (k == ELEMS - 1) ? op : OP_W'($urandom_range(0, 3));
         send_beat(beat);
      end
   endtask

   // Waits until every owed result beat has been taken.
   task automatic wait_drained();
      do @(posedge clock); while (pending != 0);
   endtask

   // Result side: runs of ready cycles, short and long, broken by stalls.
   initial begin : result_stalls
      int run_len;
      int stall_len;
      forever begin
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
         rsp_stall <= 1'b0;
         repeat (run_len) @(posedge clock);
         stall_len = idle_gap();
         if (stall_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // Cycle limit guards against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic signed [ELEM_W-1:0] a_vals [ELEMS];
      logic signed [ELEM_W-1:0] b_vals [ELEMS];
      logic [OP_W-1:0]          op;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Largest product: every element at the negative extreme.
      foreach (a_vals[k]) begin
         a_vals[k] = ELEM_MIN;
         b_vals[k] = ELEM_MIN;
      end
      send_matrices(a_vals, b_vals, OP_MUL);

      // Most negative product through the spare code, which multiplies.
      foreach (a_vals[k]) begin
         b_vals[k] = ELEM_MAX;
      end
      send_matrices(a_vals, b_vals, OP_RSVD);

      // Sum and difference at the extremes, both signs.
      foreach (a_vals[k]) begin
         a_vals[k] = (k % 2 != 0) ? ELEM_MAX : ELEM_MIN;
         b_vals[k] = a_vals[k];
      end
      send_matrices(a_vals, b_vals, OP_ADD);
      foreach (a_vals[k]) begin
         b_vals[k] = (k % 2 != 0) ? ELEM_MIN : ELEM_MAX;
      end
      send_matrices(a_vals, b_vals, OP_SUB);

      // Random matrices with random operations, some sent without any gaps.
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         foreach (a_vals[k]) begin
            a_vals[k] = random_elem();
            b_vals[k] = random_elem();
         end
         op = OP_W'($urandom_range(0, 3));
         send_matrices(a_vals, b_vals, op);
         // Hold off now and then until the block has returned everything owed.
         if (round == 15 || round == 30) begin
            req_valid <= 1'b0;
            wait_drained();
         end
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
